// File: rtl/core/r6gf_pkg.sv
package r6gf_pkg;

    // Word geometry: eight byte lanes in a 64-bit word.
    localparam int WORD_BYTES    = 8;
    localparam int WORD_W        = 64;
    localparam int LANES_DEFAULT = 8;

    // Stripe limits.
    localparam int MAX_DATA_CHUNKS    = 32;
    localparam int MIN_ENCODE_CHUNKS  = 2;
    localparam int MIN_RECOVER_CHUNKS = 3;

    // Field polynomial x^8 + x^4 + x^3 + x^2 + 1.
    localparam logic [8:0] GF_POLY = 9'h11d;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_FIRST  = 2'd2;
    localparam logic [1:0] REG_SECOND = 2'd3;

    // Operation modes.
    localparam logic MODE_ENCODE  = 1'b0;
    localparam logic MODE_RECOVER = 1'b1;

    // Chunk roles on the input channel.
    localparam logic [1:0] ROLE_DATA = 2'd0;
    localparam logic [1:0] ROLE_P    = 2'd1;
    localparam logic [1:0] ROLE_Q    = 2'd2;

    // Result kinds and status codes.
    localparam logic [1:0] KIND_Q      = 2'd0;
    localparam logic [1:0] KIND_FIRST  = 2'd1;
    localparam logic [1:0] KIND_SECOND = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Per-cycle commands from the sequencer to every byte lane.
    typedef struct packed {
        logic acc_q;       // Q sum ^= coef * byte (encode)
        logic acc_p;       // a term ^= byte
        logic acc_qs_mul;  // b term ^= coef * byte
        logic acc_qs_raw;  // b term ^= byte (Q parity word)
        logic clr_q;       // clear the Q sum
        logic clr_pq;      // clear the a and b terms
        logic mix;         // form g1*a^b and g0*a^b
        logic scale;       // multiply both by the inverse
    } lane_ctrl_t;

    // Multiply by alpha = 2.
    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

    // General GF(2^8) multiply, shift and add over the eight bits of b.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_xtime(sh);
        end
        return acc;
    endfunction

    // alpha^e for a chunk index.
    function automatic logic [7:0] gf_alpha_pow(input logic [4:0] e);
        logic [7:0] r;
        case (e)
            5'd0:    r = 8'h01;
            5'd1:    r = 8'h02;
            5'd2:    r = 8'h04;
            5'd3:    r = 8'h08;
            5'd4:    r = 8'h10;
            5'd5:    r = 8'h20;
            5'd6:    r = 8'h40;
            5'd7:    r = 8'h80;
            5'd8:    r = 8'h1d;
            5'd9:    r = 8'h3a;
            5'd10:   r = 8'h74;
            5'd11:   r = 8'he8;
            5'd12:   r = 8'hcd;
            5'd13:   r = 8'h87;
            5'd14:   r = 8'h13;
            5'd15:   r = 8'h26;
            5'd16:   r = 8'h4c;
            5'd17:   r = 8'h98;
            5'd18:   r = 8'h2d;
            5'd19:   r = 8'h5a;
            5'd20:   r = 8'hb4;
            5'd21:   r = 8'h75;
            5'd22:   r = 8'hea;
            5'd23:   r = 8'hc9;
            5'd24:   r = 8'h8f;
            5'd25:   r = 8'h03;
            5'd26:   r = 8'h06;
            5'd27:   r = 8'h0c;
            5'd28:   r = 8'h18;
            5'd29:   r = 8'h30;
            5'd30:   r = 8'h60;
            5'd31:   r = 8'hc0;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/raid6_gf8_parity_engine_top.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      chunk_role, chunk_index, data_word, flags
// m_        out        m_valid / m_ready      result_word, result_kind, status, flags
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Words without last_of_column stream at one word per cycle while the inverse unit is idle.
// A word with last_of_column holds s_ready low while the results are formed: in encode mode
// the Q load, in recover mode mix, scale and two output loads; output stalls hold it longer.
// After reset and after every configuration write the inverse unit runs with s_ready low;
// it computes 1/(alpha^m0 ^ alpha^m1) by square and multiply steps.
// A stalled m_ready holds the output register; input words keep flowing until a
// column end needs it.
module raid6_gf8_parity_engine_top #(
    parameter int LANES = r6gf_pkg::LANES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input word channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_chunk_role,
    input  logic [4:0]                  s_chunk_index,
    input  logic [r6gf_pkg::WORD_W-1:0] s_data_word,
    input  logic                        s_last_of_column,
    input  logic                        s_last_column,
    // Result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [r6gf_pkg::WORD_W-1:0] m_result_word,
    output logic [1:0]                  m_result_kind,
    output logic                        m_status,
    output logic                        m_last_of_run,
    output logic                        m_stripe_end,
    // Configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [5:0]                  cfg_data
);
    import r6gf_pkg::*;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_FIN   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_OUT0  = 3'd3;
    localparam logic [2:0] ST_OUT1  = 3'd4;

    logic       mode_reg;
    logic [5:0] count_reg;
    logic [4:0] first_reg;
    logic [4:0] second_reg;

    logic [2:0] state_reg, state_next;
    logic       lc_reg, lc_next;

    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [1:0]        kind_reg, kind_next;
    logic              status_reg, status_next;
    logic              last_reg, last_next;
    logic              se_reg, se_next;

    logic       cfg_write;
    logic       cfg_ok;
    logic       count_ok;
    logic [7:0] g0, g1, coef, inv;
    logic       inv_busy;
    logic       in_take;
    logic       idx_in_range;
    logic       idx_missing;
    logic       out_free;
    lane_ctrl_t ctrl;

    logic [WORD_W-1:0] q_word, d0_word, d1_word;

    // Configuration registers; every write restarts the inverse unit.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_ENCODE;
            count_reg  <= 6'd3;
            first_reg  <= 5'd0;
            second_reg <= 5'd1;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_COUNT:  count_reg  <= cfg_data;
                REG_FIRST:  first_reg  <= cfg_data[4:0];
                REG_SECOND: second_reg <= cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    // Settings check for the selected mode.
    assign count_ok = {3'b000, count_reg} <= 9'(MAX_DATA_CHUNKS);
    always_comb begin
        if (mode_reg == MODE_ENCODE) begin
            cfg_ok = count_ok && (count_reg >= 6'(MIN_ENCODE_CHUNKS));
        end else begin
            cfg_ok = count_ok && (count_reg >= 6'(MIN_RECOVER_CHUNKS))
                     && (first_reg < second_reg)
                     && ({1'b0, second_reg} < count_reg);
        end
    end

    // Field coefficients.
    assign g0   = gf_alpha_pow(first_reg);
    assign g1   = gf_alpha_pow(second_reg);
    assign coef = gf_alpha_pow(s_chunk_index);

    r6gf_inv u_inv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_write),
        .x       (g0 ^ g1),
        .busy    (inv_busy),
        .inv_out (inv)
    );

    // Byte lanes; lanes from index LANES upward read as zero.
    for (genvar l = 0; l < WORD_BYTES; l++) begin : g_lane
        if (l < LANES) begin : g_on
            r6gf_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .in_byte (s_data_word[8*l +: 8]),
                .coef    (coef),
                .g0      (g0),
                .g1      (g1),
                .inv     (inv),
                .q_byte  (q_word[8*l +: 8]),
                .d0_byte (d0_word[8*l +: 8]),
                .d1_byte (d1_word[8*l +: 8])
            );
        end else begin : g_off
            assign q_word[8*l +: 8]  = 8'h00;
            assign d0_word[8*l +: 8] = 8'h00;
            assign d1_word[8*l +: 8] = 8'h00;
        end
    end

    assign s_ready      = (state_reg == ST_RUN) && !inv_busy;
    assign in_take      = s_valid && s_ready;
    assign idx_in_range = {1'b0, s_chunk_index} < count_reg;
    assign idx_missing  = (s_chunk_index == first_reg) || (s_chunk_index == second_reg);
    assign out_free     = !m_valid_reg || m_ready;

    // Sequencer: accumulate, then form and merge the lane results into the output register.
    always_comb begin
        ctrl         = '0;
        state_next   = state_reg;
        lc_next      = lc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        word_next    = word_reg;
        kind_next    = kind_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        se_next      = se_reg;
        case (state_reg)
            ST_RUN: begin
                if (in_take) begin
                    if (cfg_ok) begin
                        if (mode_reg == MODE_ENCODE) begin
                            ctrl.acc_q = (s_chunk_role == ROLE_DATA) && idx_in_range;
                        end else begin
                            ctrl.acc_qs_mul = (s_chunk_role == ROLE_DATA) && idx_in_range
                                              && !idx_missing;
                            ctrl.acc_p      = ctrl.acc_qs_mul || (s_chunk_role == ROLE_P);
                            ctrl.acc_qs_raw = (s_chunk_role == ROLE_Q);
                        end
                    end
                    if (s_last_of_column) begin
                        lc_next    = s_last_column;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!cfg_ok) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        word_next    = '0;
                        kind_next    = KIND_NONE;
                        status_next  = STATUS_BAD;
                        last_next    = 1'b1;
                        se_next      = lc_reg;
                        ctrl.clr_q   = 1'b1;
                        ctrl.clr_pq  = 1'b1;
                        state_next   = ST_RUN;
                    end
                end else if (mode_reg == MODE_ENCODE) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        word_next    = q_word;
                        kind_next    = KIND_Q;
                        status_next  = STATUS_OK;
                        last_next    = 1'b1;
                        se_next      = lc_reg;
                        ctrl.clr_q   = 1'b1;
                        state_next   = ST_RUN;
                    end
                end else begin
                    ctrl.mix    = 1'b1;
                    ctrl.clr_pq = 1'b1;
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE: begin
                ctrl.scale = 1'b1;
                state_next = ST_OUT0;
            end
            ST_OUT0: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    word_next    = d0_word;
                    kind_next    = KIND_FIRST;
                    status_next  = STATUS_OK;
                    last_next    = 1'b0;
                    se_next      = lc_reg;
                    state_next   = ST_OUT1;
                end
            end
            ST_OUT1: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    word_next    = d1_word;
                    kind_next    = KIND_SECOND;
                    status_next  = STATUS_OK;
                    last_next    = 1'b1;
                    se_next      = lc_reg;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lc_reg     <= lc_next;
        word_reg   <= word_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        se_reg     <= se_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_word = word_reg;
    assign m_result_kind = kind_reg;
    assign m_status      = status_reg;
    assign m_last_of_run = last_reg;
    assign m_stripe_end  = se_reg;

    // A column end always stops the input in the cycle after it is accepted.
    ap_col_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_of_column |=> !s_ready)
        else $error("input accepted right after a column end");

    // A configuration write blocks input while the inverse is recomputed.
    ap_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready)
        else $error("input open during inverse recompute");

    // The second recovered word follows the first at once.
    ap_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_result_kind == KIND_FIRST
        |=> m_valid && m_result_kind == KIND_SECOND)
        else $error("second recovered word missing");

    // Error results carry the error status, a zero word and end the run.
    ap_error_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_NONE
        |-> m_status == STATUS_BAD && m_last_of_run && m_result_word == '0)
        else $error("malformed error result");

    // Good results never carry the no-result kind.
    ap_ok_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_OK |-> m_result_kind != KIND_NONE)
        else $error("ok status with no-result kind");

endmodule

// File: rtl/core/r6gf_lane.sv
module r6gf_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  r6gf_pkg::lane_ctrl_t   ctrl,
    input  logic [7:0]             in_byte,
    input  logic [7:0]             coef,
    input  logic [7:0]             g0,
    input  logic [7:0]             g1,
    input  logic [7:0]             inv,
    output logic [7:0]             q_byte,
    output logic [7:0]             d0_byte,
    output logic [7:0]             d1_byte
);
    import r6gf_pkg::*;

    logic [7:0] q_acc_reg, q_acc_next;
    logic [7:0] p_syn_reg, p_syn_next;
    logic [7:0] q_syn_reg, q_syn_next;
    logic [7:0] t0_reg, t0_next;
    logic [7:0] t1_reg, t1_next;
    logic [7:0] prod;

    // Scaled input byte, shared by the encode sum and the b term.
    assign prod = gf_mul(in_byte, coef);

    // Accumulators: a clear always wins over an add.
    always_comb begin
        q_acc_next = q_acc_reg;
        p_syn_next = p_syn_reg;
        q_syn_next = q_syn_reg;
        if (ctrl.clr_q) begin
            q_acc_next = '0;
        end else if (ctrl.acc_q) begin
            q_acc_next = q_acc_reg ^ prod;
        end
        if (ctrl.clr_pq) begin
            p_syn_next = '0;
            q_syn_next = '0;
        end else begin
            p_syn_next = p_syn_reg ^ (ctrl.acc_p ? in_byte : 8'h00);
            q_syn_next = q_syn_reg ^ (ctrl.acc_qs_mul ? prod : 8'h00)
                                   ^ (ctrl.acc_qs_raw ? in_byte : 8'h00);
        end
    end

    // Two-step solve of the 2x2 system, one multiply per register.
    always_comb begin
        t0_next = t0_reg;
        t1_next = t1_reg;
        if (ctrl.mix) begin
            t0_next = gf_mul(p_syn_reg, g1) ^ q_syn_reg;
            t1_next = gf_mul(p_syn_reg, g0) ^ q_syn_reg;
        end else if (ctrl.scale) begin
            t0_next = gf_mul(t0_reg, inv);
            t1_next = gf_mul(t1_reg, inv);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_acc_reg <= '0;
            p_syn_reg <= '0;
            q_syn_reg <= '0;
        end else begin
            q_acc_reg <= q_acc_next;
            p_syn_reg <= p_syn_next;
            q_syn_reg <= q_syn_next;
        end
    end

    always_ff @(posedge aclk) begin
        t0_reg <= t0_next;
        t1_reg <= t1_next;
    end

    assign q_byte  = q_acc_reg;
    assign d0_byte = t0_reg;
    assign d1_byte = t1_reg;

endmodule

// File: rtl/core/r6gf_inv.sv
module r6gf_inv (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [7:0] x,
    output logic       busy,
    output logic [7:0] inv_out
);
    import r6gf_pkg::*;

    // Load step, then seven square steps interleaved with seven multiply steps.
    localparam logic [3:0] LAST_STEP = 4'd14;

    logic       busy_reg, busy_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] s_reg, s_next;
    logic [7:0] r_reg, r_next;

    // x^254 = x^2 * x^4 * ... * x^128; zero maps to zero.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        s_next    = s_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                s_next = x;
                r_next = 8'h01;
            end else if (cnt_reg[0]) begin
                s_next = gf_mul(s_reg, s_reg);
            end else begin
                r_next = gf_mul(r_reg, s_reg);
            end
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg <= s_next;
        r_reg <= r_next;
    end

    assign busy    = busy_reg;
    assign inv_out = r_reg;

endmodule
